@@ hw/rtl/cbm_pkg.sv @@
// Package: shared codes, address constants and types of the bank mapper.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  // Request kinds carried in the mode field
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;

  // Write decode: address mask and decoded register addresses
  localparam logic [15:0] ADDR_MASK    = 16'hF80C;
  localparam logic [15:0] CHR_FIRST    = 16'hB000;
  localparam logic [15:0] CHR_LAST     = 16'hE00C;
  localparam logic [15:0] PRG0_ADDR    = 16'h8800;
  localparam logic [15:0] PRG1_ADDR    = 16'hA800;
  localparam logic [15:0] PRG2_ADDR    = 16'hA000;
  localparam logic [15:0] MIRROR_ADDR  = 16'h9800;
  localparam logic [15:0] CNT_LO_ADDR  = 16'hF000;
  localparam logic [15:0] CNT_HI_ADDR  = 16'hF004;
  localparam logic [15:0] IRQ_EN_ADDR  = 16'hF008;
  localparam logic [15:0] IRQ_OFS_ADDR = 16'hF00C;

  // CHR index correction for address bits 13..11
  localparam logic [2:0] CHR_IDX_BASE = 3'd6;

  // IRQ compare point and prescale offset
  localparam logic [8:0] IRQ_MATCH  = 9'd238;
  localparam logic [4:0] OFFSET_SET = 5'd16;

  // 8 KiB CPU pages, address bits 15..13
  localparam logic [2:0] PAGE_6000 = 3'd3;
  localparam logic [2:0] PAGE_8000 = 3'd4;
  localparam logic [2:0] PAGE_A000 = 3'd5;
  localparam logic [2:0] PAGE_C000 = 3'd6;
  localparam logic [2:0] PAGE_E000 = 3'd7;

  localparam logic [7:0] PRG_FIXED_LAST = 8'hFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_CHR,
    OP_PRG0,
    OP_PRG1,
    OP_PRG2,
    OP_MIRROR,
    OP_CNT_LO,
    OP_CNT_HI,
    OP_IRQ_EN,
    OP_IRQ_OFS
  } op_t;

  // Decoded request handed from the decoder to the state block
  typedef struct packed {
    op_t        op;
    logic [2:0] chr_idx;
    logic       chr_hi;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/cbm_in_if.sv @@
// Interface: input request channel of the bank mapper.
`timescale 1ns / 1ps
`default_nettype none

interface cbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] cpu_address;
  logic [7:0]  write_data;
  logic [12:0] ppu_address;

  modport source (output valid, mode, cpu_address, write_data, ppu_address, input ready);
  modport sink   (input valid, mode, cpu_address, write_data, ppu_address, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cbm_out_if.sv @@
// Interface: result channel of the bank mapper.
`timescale 1ns / 1ps
`default_nettype none

interface cbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] prg_bank;
  logic [7:0] chr_bank;
  logic [1:0] mirroring;
  logic       irq_pending;

  modport source (output valid, prg_bank, chr_bank, mirroring, irq_pending, input ready);
  modport sink   (input valid, prg_bank, chr_bank, mirroring, irq_pending, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cbm_decode.sv @@
// Decoder: turns one request into a register-update command.
`timescale 1ns / 1ps
`default_nettype none

module cbm_decode (
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] cpu_address,
  input  wire logic [7:0]  write_data,
  output cbm_pkg::cmd_t    cmd
);

  logic [15:0] masked;
  logic        chr_hit;

  assign masked  = cpu_address & cbm_pkg::ADDR_MASK;
  assign chr_hit = (masked >= cbm_pkg::CHR_FIRST) && (masked <= cbm_pkg::CHR_LAST);

  // Pick the target register from the masked address
  always_comb begin
    cmd.op      = cbm_pkg::OP_NONE;
    cmd.chr_idx = 3'(cpu_address[13:11] - cbm_pkg::CHR_IDX_BASE) | cpu_address[5:3];
    cmd.chr_hi  = cpu_address[2];
    cmd.data    = write_data;
    if (mode == cbm_pkg::MODE_WRITE) begin
      if (cpu_address[15]) begin
        if (chr_hit) begin
          cmd.op = cbm_pkg::OP_CHR;
        end else begin
          case (masked)
            cbm_pkg::PRG0_ADDR:    cmd.op = cbm_pkg::OP_PRG0;
            cbm_pkg::PRG1_ADDR:    cmd.op = cbm_pkg::OP_PRG1;
            cbm_pkg::PRG2_ADDR:    cmd.op = cbm_pkg::OP_PRG2;
            cbm_pkg::MIRROR_ADDR:  cmd.op = cbm_pkg::OP_MIRROR;
            cbm_pkg::CNT_LO_ADDR:  cmd.op = cbm_pkg::OP_CNT_LO;
            cbm_pkg::CNT_HI_ADDR:  cmd.op = cbm_pkg::OP_CNT_HI;
            cbm_pkg::IRQ_EN_ADDR:  cmd.op = cbm_pkg::OP_IRQ_EN;
            cbm_pkg::IRQ_OFS_ADDR: cmd.op = cbm_pkg::OP_IRQ_OFS;
            default:               cmd.op = cbm_pkg::OP_NONE;
          endcase
        end
      end
    end else if (mode == cbm_pkg::MODE_TICK) begin
      cmd.op = cbm_pkg::OP_TICK;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cbm_state.sv @@
// Mapper state: bank, mirroring and IRQ registers, their update and the lookups.
`timescale 1ns / 1ps
`default_nettype none

module cbm_state (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire cbm_pkg::cmd_t cmd,
  input  wire logic [15:0]   cpu_address,
  input  wire logic [12:0]   ppu_address,
  output logic [7:0]         prg_bank,
  output logic [7:0]         chr_bank,
  output logic [1:0]         mirroring,
  output logic               irq_pending
);

  logic [7:0] prg_r   [3];
  logic [7:0] prg_nxt [3];
  logic [7:0] chr_r   [8];
  logic [7:0] chr_nxt [8];
  logic [7:0] cnt_r, cnt_nxt;
  logic [4:0] ofs_r, ofs_nxt;
  logic       en_r, en_nxt;
  logic       flag_r, flag_nxt;
  logic [1:0] mirror_r, mirror_nxt;

  // Apply the command to the current state
  always_comb begin
    prg_nxt    = prg_r;
    chr_nxt    = chr_r;
    cnt_nxt    = cnt_r;
    ofs_nxt    = ofs_r;
    en_nxt     = en_r;
    flag_nxt   = flag_r;
    mirror_nxt = mirror_r;
    case (cmd.op)
      cbm_pkg::OP_CHR: begin
        if (cmd.chr_hi) begin
          chr_nxt[cmd.chr_idx][7:4] = cmd.data[3:0];
        end else begin
          chr_nxt[cmd.chr_idx][3:0] = cmd.data[3:0];
        end
      end
      cbm_pkg::OP_PRG0:   prg_nxt[0] = cmd.data;
      cbm_pkg::OP_PRG1:   prg_nxt[1] = cmd.data;
      cbm_pkg::OP_PRG2:   prg_nxt[2] = cmd.data;
      cbm_pkg::OP_MIRROR: mirror_nxt = cmd.data[1:0];
      cbm_pkg::OP_CNT_LO: cnt_nxt[3:0] = cmd.data[3:0];
      cbm_pkg::OP_CNT_HI: cnt_nxt[7:4] = cmd.data[3:0];
      cbm_pkg::OP_IRQ_EN: begin
        en_nxt   = (cmd.data != 8'd0);
        flag_nxt = 1'b0;
        if (cmd.data == 8'd0) begin
          ofs_nxt = 5'd0;
        end
      end
      cbm_pkg::OP_IRQ_OFS: ofs_nxt = cbm_pkg::OFFSET_SET;
      cbm_pkg::OP_TICK: begin
        if (en_r) begin
          cnt_nxt = cnt_r + 8'd1;
          // compare unwrapped: match only at 238 plus the offset
          if ({1'b0, cnt_nxt} == cbm_pkg::IRQ_MATCH + {4'd0, ofs_r}) begin
            flag_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Commit the update when the request advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_r    <= '{default: 8'd0};
      chr_r    <= '{default: 8'd0};
      cnt_r    <= 8'd0;
      ofs_r    <= 5'd0;
      en_r     <= 1'b0;
      flag_r   <= 1'b0;
      mirror_r <= 2'd0;
    end else if (step) begin
      prg_r    <= prg_nxt;
      chr_r    <= chr_nxt;
      cnt_r    <= cnt_nxt;
      ofs_r    <= ofs_nxt;
      en_r     <= en_nxt;
      flag_r   <= flag_nxt;
      mirror_r <= mirror_nxt;
    end
  end

  // Report lookups against the updated state
  always_comb begin
    case (cpu_address[15:13])
      cbm_pkg::PAGE_6000: prg_bank = 8'd0;
      cbm_pkg::PAGE_8000: prg_bank = prg_nxt[0];
      cbm_pkg::PAGE_A000: prg_bank = prg_nxt[1];
      cbm_pkg::PAGE_C000: prg_bank = prg_nxt[2];
      cbm_pkg::PAGE_E000: prg_bank = cbm_pkg::PRG_FIXED_LAST;
      default:            prg_bank = 8'd0;
    endcase
  end

  assign chr_bank    = chr_nxt[ppu_address[12:10]];
  assign mirroring   = mirror_nxt;
  assign irq_pending = flag_nxt;

endmodule

`default_nettype wire

@@ hw/rtl/cartridge_bank_mapper_scanline_irq.sv @@
// Top level: cartridge bank mapper with scanline IRQ counter.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one request (CPU write, scanline tick or lookup) per cycle while the
// result channel does not stall, and returns one result per request, in order.
// A request is held in an input register; once the result register is free or
// being taken, it updates the mapper registers and its lookups are captured in
// the result register. Throughput is one request per cycle without stalls.
// The following request already sees the state left by the one before it.
// A stalled result holds in the result register while the input register keeps
// accepting until it too is full.
module cartridge_bank_mapper_scanline_irq (
  input  wire logic clk,
  input  wire logic rst_n,
  cbm_in_if.sink    in_ch,
  cbm_out_if.source out_ch
);

  logic        s1_valid_r;
  logic [1:0]  s1_mode_r;
  logic [15:0] s1_cpu_address_r;
  logic [7:0]  s1_write_data_r;
  logic [12:0] s1_ppu_address_r;
  logic        advance;

  logic        out_valid_r;
  logic [7:0]  out_prg_r;
  logic [7:0]  out_chr_r;
  logic [1:0]  out_mirror_r;
  logic        out_irq_r;

  cbm_pkg::cmd_t cmd;
  logic [7:0]    prg_bank;
  logic [7:0]    chr_bank;
  logic [1:0]    mirroring;
  logic          irq_pending;

  // Move the held request forward when the result register frees up
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_mode_r        <= in_ch.mode;
      s1_cpu_address_r <= in_ch.cpu_address;
      s1_write_data_r  <= in_ch.write_data;
      s1_ppu_address_r <= in_ch.ppu_address;
    end
  end

  cbm_decode u_decode (
    .mode        (s1_mode_r),
    .cpu_address (s1_cpu_address_r),
    .write_data  (s1_write_data_r),
    .cmd         (cmd)
  );

  cbm_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_valid_r && advance),
    .cmd         (cmd),
    .cpu_address (s1_cpu_address_r),
    .ppu_address (s1_ppu_address_r),
    .prg_bank    (prg_bank),
    .chr_bank    (chr_bank),
    .mirroring   (mirroring),
    .irq_pending (irq_pending)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_prg_r    <= prg_bank;
      out_chr_r    <= chr_bank;
      out_mirror_r <= mirroring;
      out_irq_r    <= irq_pending;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prg_bank    = out_prg_r;
  assign out_ch.chr_bank    = out_chr_r;
  assign out_ch.mirroring   = out_mirror_r;
  assign out_ch.irq_pending = out_irq_r;

endmodule

`default_nettype wire

@@ hw/rtl/cbm_checker.sv @@
// Checker: port-level assertions on the bank mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cbm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_prg_bank,
  input wire logic [7:0] out_chr_bank,
  input wire logic [1:0] out_mirroring,
  input wire logic       out_irq_pending
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prg_bank)
      && $stable(out_chr_bank) && $stable(out_mirroring) && $stable(out_irq_pending))
    else $error("stalled result changed");

  // An empty result register never blocks new requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with result register empty");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind cartridge_bank_mapper_scanline_irq cbm_checker u_cbm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_prg_bank    (out_ch.prg_bank),
  .out_chr_bank    (out_ch.chr_bank),
  .out_mirroring   (out_ch.mirroring),
  .out_irq_pending (out_ch.irq_pending)
);

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the cartridge bank mapper with scanline IRQ counter.
`timescale 1ns / 1ps

module testbench;

  // Request kinds the package leaves unnamed
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam int RANDOM_PER_PHASE = 210;
  localparam int DRAIN_CYCLES     = 8;
  localparam int TIMEOUT_CYCLES   = 250000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [12:0] ppu;
  } mapper_req_t;

  typedef struct packed {
    logic [7:0] prg;
    logic [7:0] chr;
    logic [1:0] mirr;
    logic       irq;
  } lookup_t;

  // One row of the directed table; fixed marks a hand-typed expectation
  typedef struct packed {
    mapper_req_t req;
    logic        fixed;
    lookup_t     want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cbm_in_if  in_ch ();
  cbm_out_if out_ch ();

  cartridge_bank_mapper_scanline_irq uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the mapper registers
  logic [7:0] shadow_prg [3] = '{default: '0};
  logic [7:0] shadow_chr [8] = '{default: '0};
  logic [7:0] irq_count  = '0;
  logic [4:0] irq_ofs    = '0;
  logic       irq_on     = 1'b0;
  logic       irq_raised = 1'b0;
  logic [1:0] shadow_mirror = '0;

  lookup_t pending_lookups [$];
  int      mismatch_count = 0;
  int      sender_gap_pct = 35;
  int      recv_stall_pct = 68;
  int      writes_sent = 0;
  int      ticks_sent = 0;
  int      lookups_sent = 0;
  int      irq_results = 0;

  dir_row_t directed_rows [0:25] = '{
    '{'{MODE_LOOKUP, 16'h0000, 8'h00, 13'h0000}, 1'b1, '{8'h00, 8'h00, 2'd0, 1'b0}},
    '{'{MODE_SPARE,  16'hFFFF, 8'hFF, 13'h1FFF}, 1'b1, '{8'hFF, 8'h00, 2'd0, 1'b0}},
    '{'{cbm_pkg::MODE_WRITE, 16'h7FFF, 8'hFF, 13'h1FFF}, 1'b1, '{8'h00, 8'h00, 2'd0, 1'b0}},
    '{'{cbm_pkg::MODE_WRITE, 16'h9000, 8'hFF, 13'h0000}, 1'b1, '{8'h00, 8'h00, 2'd0, 1'b0}},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::PRG0_ADDR, 8'hA5, 13'h0400}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::PRG1_ADDR, 8'h5A, 13'h0800}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::PRG2_ADDR, 8'hFF, 13'h0C00}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::MIRROR_ADDR, 8'hFF, 13'h1000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::CHR_FIRST, 8'h0F, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::CHR_FIRST | 16'h0004, 8'hFF, 13'h03FF}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::CHR_LAST, 8'hFF, 13'h1FFF}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, 16'hC008, 8'h3C, 13'h0C00}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::CNT_LO_ADDR, 8'hFD, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::CNT_HI_ADDR, 8'h0E, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::IRQ_EN_ADDR, 8'h01, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_TICK,  16'hC000, 8'h00, 13'h1C00}, 1'b0, '0},
    '{'{cbm_pkg::MODE_TICK,  16'hA000, 8'h00, 13'h1800}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::IRQ_EN_ADDR, 8'h00, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_TICK,  16'h8000, 8'h00, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::IRQ_OFS_ADDR, 8'h00, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::CNT_LO_ADDR, 8'h0D, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::CNT_HI_ADDR, 8'h0F, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_WRITE, cbm_pkg::IRQ_EN_ADDR, 8'h80, 13'h0000}, 1'b0, '0},
    '{'{cbm_pkg::MODE_TICK,  16'hE000, 8'h00, 13'h1FFF}, 1'b0, '0},
    '{'{MODE_LOOKUP, 16'hC000, 8'h00, 13'h1C00}, 1'b0, '0},
    '{'{MODE_LOOKUP, 16'h5FFF, 8'hFF, 13'h1400}, 1'b0, '0}
  };

  // Update the shadow registers with one request and return its lookups
  function automatic lookup_t apply_request(input mapper_req_t req);
    logic [15:0] masked;
    logic [2:0]  bank_sel;
    lookup_t     res;
    masked = req.addr & cbm_pkg::ADDR_MASK;
    if (req.mode == cbm_pkg::MODE_WRITE && req.addr[15]) begin
      if (masked >= cbm_pkg::CHR_FIRST && masked <= cbm_pkg::CHR_LAST) begin
        // address bit 2 picks the high nibble; the other nibble is kept
        bank_sel = (req.addr[13:11] - cbm_pkg::CHR_IDX_BASE) | req.addr[5:3];
        if (req.addr[2]) shadow_chr[bank_sel][7:4] = req.data[3:0];
        else shadow_chr[bank_sel][3:0] = req.data[3:0];
      end else begin
        case (masked)
          cbm_pkg::PRG0_ADDR:    shadow_prg[0] = req.data;
          cbm_pkg::PRG1_ADDR:    shadow_prg[1] = req.data;
          cbm_pkg::PRG2_ADDR:    shadow_prg[2] = req.data;
          cbm_pkg::MIRROR_ADDR:  shadow_mirror = req.data[1:0];
          cbm_pkg::CNT_LO_ADDR:  irq_count[3:0] = req.data[3:0];
          cbm_pkg::CNT_HI_ADDR:  irq_count[7:4] = req.data[3:0];
          cbm_pkg::IRQ_EN_ADDR: begin
            irq_on = (req.data != 8'h00);
            if (req.data == 8'h00) irq_ofs = '0;
            irq_raised = 1'b0;
          end
          cbm_pkg::IRQ_OFS_ADDR: irq_ofs = cbm_pkg::OFFSET_SET;
          default: ;
        endcase
      end
    end else if (req.mode == cbm_pkg::MODE_TICK && irq_on) begin
      // compare without wrap: count must equal match point plus offset
      irq_count = irq_count + 8'd1;
      if ({1'b0, irq_count} == cbm_pkg::IRQ_MATCH + {4'd0, irq_ofs}) irq_raised = 1'b1;
    end

    case (req.addr[15:13])
      cbm_pkg::PAGE_8000: res.prg = shadow_prg[0];
      cbm_pkg::PAGE_A000: res.prg = shadow_prg[1];
      cbm_pkg::PAGE_C000: res.prg = shadow_prg[2];
      cbm_pkg::PAGE_E000: res.prg = cbm_pkg::PRG_FIXED_LAST;
      default:            res.prg = 8'h00;
    endcase
    res.chr  = shadow_chr[req.ppu[12:10]];
    res.mirr = shadow_mirror;
    res.irq  = irq_raised;
    return res;
  endfunction

  // Build a random request, mostly register writes that the decoder accepts
  function automatic mapper_req_t random_request();
    mapper_req_t req;
    logic [15:0] spare_bits;
    int          pick;
    pick       = int'($urandom_range(99));
    req.mode   = cbm_pkg::MODE_WRITE;
    req.addr   = 16'($urandom);
    req.data   = 8'($urandom);
    req.ppu    = 13'($urandom);
    spare_bits = 16'($urandom);
    spare_bits = spare_bits & ~cbm_pkg::ADDR_MASK;
    if (pick < 30) begin
      req.mode = cbm_pkg::MODE_TICK;
    end else if (pick < 38) begin
      req.mode = $urandom_range(1) ? MODE_LOOKUP : MODE_SPARE;
    end else if (pick >= 46) begin
      case ($urandom_range(9))
        0, 1: req.addr[15:12] = 4'($urandom_range(11, 14));
        2: req.addr = cbm_pkg::PRG0_ADDR | spare_bits;
        3: req.addr = cbm_pkg::PRG1_ADDR | spare_bits;
        4: req.addr = cbm_pkg::PRG2_ADDR | spare_bits;
        5: req.addr = cbm_pkg::MIRROR_ADDR | spare_bits;
        6: req.addr = cbm_pkg::CNT_LO_ADDR | spare_bits;
        7: begin
          // bias the high nibble near the match points
          req.addr = cbm_pkg::CNT_HI_ADDR | spare_bits;
          if ($urandom_range(3) != 0) req.data[3:1] = 3'b111;
        end
        8: begin
          req.addr = cbm_pkg::IRQ_EN_ADDR | spare_bits;
          if ($urandom_range(3) == 0) req.data = 8'h00;
        end
        default: req.addr = cbm_pkg::IRQ_OFS_ADDR | spare_bits;
      endcase
    end
    return req;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Drive one request, hold it until accepted, then record its expectation
  task automatic send_request(input mapper_req_t req, input logic fixed, input lookup_t want);
    lookup_t predicted;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= req.mode;
    in_ch.cpu_address <= req.addr;
    in_ch.write_data  <= req.data;
    in_ch.ppu_address <= req.ppu;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_request(req);
    pending_lookups.push_back(fixed ? want : predicted);
    case (req.mode)
      cbm_pkg::MODE_WRITE: writes_sent++;
      cbm_pkg::MODE_TICK:  ticks_sent++;
      default:             lookups_sent++;
    endcase
  endtask

  // Receiver: stall at the rate of the current phase
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    lookup_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("result with no request pending", int'(out_ch.prg_bank), -1);
      end else begin
        want = pending_lookups.pop_front();
        if (out_ch.prg_bank != want.prg)
          report_mismatch("prg_bank", int'(out_ch.prg_bank), int'(want.prg));
        if (out_ch.chr_bank != want.chr)
          report_mismatch("chr_bank", int'(out_ch.chr_bank), int'(want.chr));
        if (out_ch.mirroring != want.mirr)
          report_mismatch("mirroring", int'(out_ch.mirroring), int'(want.mirr));
        if (out_ch.irq_pending != want.irq)
          report_mismatch("irq_pending", int'(out_ch.irq_pending), int'(want.irq));
        if (out_ch.irq_pending) irq_results++;
      end
    end
  end

  // Stimulus: reset, directed table, then three random phases
  initial begin
    mapper_req_t req;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_LOOKUP;
    in_ch.cpu_address <= '0;
    in_ch.write_data  <= '0;
    in_ch.ppu_address <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      sender_gap_pct = (phase == 0) ? 35 : (phase == 1) ? 68 : 0;
      recv_stall_pct = (phase == 0) ? 68 : (phase == 1) ? 35 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        req = random_request();
        send_request(req, 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let stragglers show up
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d writes, %0d scanline ticks, %0d lookups",
             writes_sent + ticks_sent + lookups_sent, writes_sent, ticks_sent, lookups_sent);
    $display("Results with IRQ pending: %0d, mismatches: %0d", irq_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Timeout with %0d results outstanding", pending_lookups.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
